// ===== rtl/core/dssm_pkg.sv =====
// Shared types, codes and defaults for the dual stack shared memory unit.
`timescale 1ns / 1ps

package dssm_pkg;

  localparam int unsigned DEPTH_DEFAULT = 8;
  localparam int unsigned WORD_W        = 32;
  localparam int unsigned REQ_W         = 3;
  localparam int unsigned STATUS_W      = 2;

  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 40;

  localparam logic [REQ_W-1:0] REQ_PUSH_LO = 3'd0;
  localparam logic [REQ_W-1:0] REQ_POP_LO  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_PEEK_LO = 3'd2;
  localparam logic [REQ_W-1:0] REQ_PUSH_HI = 3'd3;
  localparam logic [REQ_W-1:0] REQ_POP_HI  = 3'd4;
  localparam logic [REQ_W-1:0] REQ_PEEK_HI = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;

  localparam logic [WORD_W-1:0] MOST_NEGATIVE = 32'h8000_0000;

  // Where the result word comes from once the item has been processed.
  typedef enum logic [1:0] {
    RSEL_ZERO,
    RSEL_MEM,
    RSEL_MOST_NEG
  } dssm_rsel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;  // an input item is taken this cycle
    logic load;    // the result moves into the output register
  } dssm_cmd_t;

endpackage

// ===== rtl/core/dssm_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps

module dssm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/dssm_datapath.sv =====
// Stack pointers, request decode, shared memory and output payload register.
`timescale 1ns / 1ps

module dssm_datapath import dssm_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEFAULT
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  dssm_cmd_t                  cmd_i,
  input  logic [REQ_W-1:0]           req_type_i,
  input  logic signed [WORD_W-1:0]   push_value_i,
  output logic signed [WORD_W-1:0]   read_value_o,
  output logic [STATUS_W-1:0]        status_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DepthC = CW'(DEPTH);

  logic [CW-1:0]       low_count_q, low_count_d;
  logic [CW-1:0]       high_count_q, high_count_d;
  logic [STATUS_W-1:0] res_status_q, res_status_d;
  dssm_rsel_e          res_sel_q, res_sel_d;
  logic [WORD_W-1:0]   out_value_q;
  logic [STATUS_W-1:0] out_status_q;

  logic [CW:0]       used;
  logic              full;
  logic [CW-1:0]     high_top;
  logic [CW-1:0]     high_next;
  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [WORD_W-1:0] ram_rdata;

  assign used      = {1'b0, low_count_q} + {1'b0, high_count_q};
  assign full      = (used >= {1'b0, DepthC});
  // Entry of the top of the high stack, and the entry a high push fills.
  assign high_top  = DepthC - high_count_q;
  assign high_next = high_top - CW'(1);

  always_comb begin
    low_count_d  = low_count_q;
    high_count_d = high_count_q;
    res_status_d = res_status_q;
    res_sel_d    = res_sel_q;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_waddr    = low_count_q[AW-1:0];
    ram_raddr    = high_top[AW-1:0];
    if (cmd_i.accept) begin
      res_status_d = ST_OK;
      res_sel_d    = RSEL_ZERO;
      case (req_type_i)
        REQ_PUSH_LO: begin
          if (full) begin
            res_status_d = ST_OVERFLOW;
          end else begin
            ram_we      = 1'b1;
            ram_waddr   = low_count_q[AW-1:0];
            low_count_d = low_count_q + CW'(1);
          end
        end
        REQ_POP_LO, REQ_PEEK_LO: begin
          if (low_count_q == '0) begin
            res_status_d = ST_EMPTY;
            res_sel_d    = RSEL_MOST_NEG;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = AW'(low_count_q - CW'(1));
            res_sel_d = RSEL_MEM;
            if (req_type_i == REQ_POP_LO) begin
              low_count_d = low_count_q - CW'(1);
            end
          end
        end
        REQ_PUSH_HI: begin
          if (full) begin
            res_status_d = ST_OVERFLOW;
          end else begin
            ram_we       = 1'b1;
            ram_waddr    = high_next[AW-1:0];
            high_count_d = high_count_q + CW'(1);
          end
        end
        REQ_POP_HI, REQ_PEEK_HI: begin
          if (high_count_q == '0) begin
            res_status_d = ST_EMPTY;
            res_sel_d    = RSEL_MOST_NEG;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = high_top[AW-1:0];
            res_sel_d = RSEL_MEM;
            if (req_type_i == REQ_POP_HI) begin
              high_count_d = high_count_q - CW'(1);
            end
          end
        end
        default: begin
          res_status_d = ST_OK;
        end
      endcase
    end
  end

  dssm_ram #(
    .WIDTH(WORD_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(push_value_i),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_count_q  <= '0;
      high_count_q <= '0;
    end else begin
      low_count_q  <= low_count_d;
      high_count_q <= high_count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_status_q <= res_status_d;
    res_sel_q    <= res_sel_d;
    if (cmd_i.load) begin
      out_status_q <= res_status_q;
      case (res_sel_q)
        RSEL_MEM:      out_value_q <= ram_rdata;
        RSEL_MOST_NEG: out_value_q <= MOST_NEGATIVE;
        default:       out_value_q <= '0;
      endcase
    end
  end

  assign read_value_o = out_value_q;
  assign status_o     = out_status_q;

  // The two stacks never hold more words than the memory has entries.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, low_count_q} + {1'b0, high_count_q}) <= {1'b0, DepthC})
    else $error("stack counts exceed memory depth");

  // A refused push or an empty pop leaves both pointers untouched.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.accept && (res_status_d != ST_OK)
    |=> $stable(low_count_q) && $stable(high_count_q))
    else $error("pointer moved on a failed request");

endmodule

// ===== rtl/core/dssm_ctrl.sv =====
// Controller: input and output handshakes and sequencing of one item at a time.
`timescale 1ns / 1ps

module dssm_ctrl import dssm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output dssm_cmd_t cmd_o
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_RESP = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic accept, load;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  // The memory read lands in this state; move on once the output register frees up.
  assign load       = (state_q == S_RESP) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (accept) state_d = S_RESP;
      S_RESP:  if (load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign cmd_o.accept = accept;
  assign cmd_o.load   = load;

  // An accepted item closes the input until its result is loaded.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_RESP) && !in_ready_o)
    else $error("input open while an item is in flight");

  // A new result only appears after an item finished its memory access.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_RESP))
    else $error("result shown without a processed item");

endmodule

// ===== rtl/core/dual_stack_shared_memory_unit.sv =====
// Top level of the dual stack shared memory unit.
// Two LIFO stacks live in one memory of DEPTH words: the low stack grows up
// from entry 0, the high stack grows down from entry DEPTH-1.
// Input channel s_axis: one item is a request (push, pop or peek of either
// stack) with the word to push. Output channel m_axis: exactly one item per
// request, with the popped or peeked word and a status (ok, overflow, empty).
// A push into a full memory is refused with overflow; a pop or peek of an
// empty stack returns the most negative word with status empty.
// The accepting edge registers the memory read and the result select; the
// result then moves into the output register once that register is free.
// The input closes while a request is in flight, due to the registered
// read of the shared memory; requests are handled one at a time.
// While the receiver stalls, the finished result waits in the output
// register and one more item is accepted and processed; the input then
// closes until the output register is taken.
// Reset empties both stacks at once; memory contents are not cleared and
// are only read after a push has written them.
`timescale 1ns / 1ps

module dual_stack_shared_memory_unit import dssm_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEFAULT
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // req_type[2:0], push_value[34:3]
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata    // read_value[31:0], status[33:32]
);

  dssm_cmd_t                cmd;
  logic [REQ_W-1:0]         req_type;
  logic signed [WORD_W-1:0] push_value;
  logic signed [WORD_W-1:0] read_value;
  logic [STATUS_W-1:0]      status;

  assign req_type   = s_axis_tdata[REQ_W-1:0];
  assign push_value = s_axis_tdata[REQ_W+WORD_W-1:REQ_W];

  dssm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .cmd_o      (cmd)
  );

  dssm_datapath #(
    .DEPTH(DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .req_type_i  (req_type),
    .push_value_i(push_value),
    .read_value_o(read_value),
    .status_o    (status)
  );

  assign m_axis_tdata = {{(OUT_DATA_W - WORD_W - STATUS_W){1'b0}}, status, read_value};

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the dual stack shared memory unit.
`timescale 1ns / 1ps

module testbench import dssm_pkg::*; ();

  localparam int unsigned STACK_DEPTH     = DEPTH_DEFAULT;
  localparam int unsigned ITEMS_PER_PHASE = 667;
  localparam int unsigned HOLD_CYCLES     = 60;
  localparam int unsigned QUIET_LIMIT     = 2000;
  localparam int unsigned SETTLE_CYCLES   = 10;

  // Request codes the block does not use; they must come back as zero with ok.
  localparam logic [REQ_W-1:0] REQ_UNUSED_A = 3'd6;
  localparam logic [REQ_W-1:0] REQ_UNUSED_B = 3'd7;

  typedef struct packed {
    logic [WORD_W-1:0]   value;
    logic [STATUS_W-1:0] status;
  } stack_response_t;

  // Mirror of both stacks and the queue of responses they must produce.
  class stack_tracker;
    logic [WORD_W-1:0] words [STACK_DEPTH];
    int unsigned       low_count;
    int unsigned       high_count;
    stack_response_t   pending[$];
    int unsigned       requests;
    int unsigned       responses;
    int unsigned       overflows;
    int unsigned       empties;
    int unsigned       mismatches;

    function new();
      low_count  = 0;
      high_count = 0;
      requests   = 0;
      responses  = 0;
      overflows  = 0;
      empties    = 0;
      mismatches = 0;
    endfunction

    function void apply_request(logic [REQ_W-1:0] req, logic [WORD_W-1:0] word);
      stack_response_t resp;
      logic            full;
      full        = (low_count + high_count) >= STACK_DEPTH;
      resp.value  = '0;
      resp.status = ST_OK;
      requests++;
      case (req)
        REQ_PUSH_LO: begin
          if (full) begin
            resp.status = ST_OVERFLOW;
          end else begin
            words[low_count] = word;
            low_count++;
          end
        end
        REQ_POP_LO, REQ_PEEK_LO: begin
          if (low_count == 0) begin
            resp.value  = MOST_NEGATIVE;
            resp.status = ST_EMPTY;
          end else begin
            resp.value = words[low_count-1];
            if (req == REQ_POP_LO) low_count--;
          end
        end
        REQ_PUSH_HI: begin
          if (full) begin
            resp.status = ST_OVERFLOW;
          end else begin
            high_count++;
            words[STACK_DEPTH-high_count] = word;
          end
        end
        REQ_POP_HI, REQ_PEEK_HI: begin
          if (high_count == 0) begin
            resp.value  = MOST_NEGATIVE;
            resp.status = ST_EMPTY;
          end else begin
            resp.value = words[STACK_DEPTH-high_count];
            if (req == REQ_POP_HI) high_count--;
          end
        end
        default: begin
        end
      endcase
      pending.push_back(resp);
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      mismatches++;
    endtask

    task check_response(logic [OUT_DATA_W-1:0] data);
      stack_response_t     want;
      logic [WORD_W-1:0]   got_value;
      logic [STATUS_W-1:0] got_status;
      got_value  = data[WORD_W-1:0];
      got_status = data[WORD_W +: STATUS_W];
      responses++;
      if (pending.size() == 0) begin
        report($sformatf("response %0d arrived with none outstanding: %h", responses, data));
        return;
      end
      want = pending.pop_front();
      if (got_value !== want.value) begin
        report($sformatf("response %0d read_value %h, predicted %h",
                         responses, got_value, want.value));
      end
      if (got_status !== want.status) begin
        report($sformatf("response %0d status %0d, predicted %0d",
                         responses, got_status, want.status));
      end
      if (want.status == ST_OVERFLOW) overflows++;
      if (want.status == ST_EMPTY) empties++;
    endtask
  endclass

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;  // req_type[2:0], push_value[34:3]
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;        // read_value[31:0], status[33:32]

  stack_tracker board = new();

  int unsigned send_idle_pct = 34;
  int unsigned recv_idle_pct = 83;
  int unsigned hold_tickets  = 0;
  int unsigned hold_served   = 0;
  int unsigned hold_left     = 0;
  int unsigned quiet_cycles  = 0;

  dual_stack_shared_memory_unit #(
    .DEPTH(STACK_DEPTH)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #2 clk_i = ~clk_i;

  // Offers one request, starting and ending at a falling edge.
  task automatic send_request(logic [REQ_W-1:0] req, logic [WORD_W-1:0] word);
    logic [63:0] noise;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      noise = {$urandom, $urandom};
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= noise[IN_DATA_W-1:0];
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(IN_DATA_W-WORD_W-REQ_W){1'b0}}, word, req};
    do @(posedge clk_i); while (!s_axis_tready);
    board.apply_request(req, word);
    @(negedge clk_i);
  endtask

  // The sender stops until every outstanding response has come back.
  task automatic wait_for_drain();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (board.pending.size() != 0);
  endtask

  // Receiver: random backpressure, plus a long hold-off at each phase start.
  always @(negedge clk_i) begin
    if (hold_tickets != hold_served) begin
      hold_served = hold_tickets;
      hold_left   = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      board.check_response(m_axis_tdata);
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Timeout: no item moved for %0d cycles, %0d responses outstanding",
               quiet_cycles, board.pending.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    logic [REQ_W-1:0]  req;
    logic [WORD_W-1:0] word;
    int unsigned       bias;
    int unsigned       burst;
    int unsigned       push_cut;
    int unsigned       pick;
    burst = 0;
    bias  = 0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Both stacks empty after reset.
    send_request(REQ_POP_LO,  32'h0000_0000);
    send_request(REQ_PEEK_LO, 32'hFFFF_FFFF);
    send_request(REQ_POP_HI,  32'h0000_0000);
    send_request(REQ_PEEK_HI, 32'hFFFF_FFFF);
    send_request(REQ_PUSH_LO, 32'h7FFF_FFFF);
    send_request(REQ_PUSH_HI, 32'h8000_0000);
    send_request(REQ_PEEK_LO, 32'h0000_0000);
    send_request(REQ_PEEK_HI, 32'h0000_0000);
    send_request(REQ_UNUSED_A, 32'hFFFF_FFFF);
    send_request(REQ_UNUSED_B, 32'h1234_5678);
    // Fill until the stacks meet, then push into the full memory on both sides.
    send_request(REQ_PUSH_LO, 32'hFFFF_FFFF);
    send_request(REQ_PUSH_LO, 32'h0000_0000);
    send_request(REQ_PUSH_LO, 32'h8000_0000);
    send_request(REQ_PUSH_HI, 32'h7FFF_FFFF);
    send_request(REQ_PUSH_HI, 32'hFFFF_FFFF);
    send_request(REQ_PUSH_HI, 32'h0000_0001);
    send_request(REQ_PUSH_LO, 32'hA5A5_A5A5);
    send_request(REQ_PUSH_HI, 32'h5A5A_5A5A);
    send_request(REQ_PEEK_HI, 32'h0000_0000);
    send_request(REQ_PEEK_LO, 32'h0000_0000);
    send_request(REQ_POP_HI,  32'h0000_0000);
    send_request(REQ_PUSH_LO, 32'hC3C3_C3C3);
    send_request(REQ_POP_LO,  32'h0000_0000);
    send_request(REQ_POP_LO,  32'h0000_0000);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 34;
          recv_idle_pct <= 83;
        end
        1: begin
          send_idle_pct  = 83;
          recv_idle_pct <= 34;
        end
        default: begin
          send_idle_pct  = 0;
          recv_idle_pct <= 0;
        end
      endcase
      hold_tickets <= hold_tickets + 1;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (n == ITEMS_PER_PHASE / 2) wait_for_drain();
        // Bursts lean toward filling or emptying, or stay balanced, so that
        // full and empty memories are reached often.
        if (burst == 0) begin
          bias  = $urandom_range(0, 2);
          burst = $urandom_range(4, 16);
        end
        burst--;
        push_cut = (bias == 0) ? 75 : ((bias == 1) ? 20 : 45);
        pick     = $urandom_range(0, 99);
        if (pick < 2) begin
          req = (pick == 0) ? REQ_UNUSED_A : REQ_UNUSED_B;
        end else begin
          pick = $urandom_range(0, 99);
          if (pick < push_cut) begin
            req = $urandom_range(0, 1) ? REQ_PUSH_HI : REQ_PUSH_LO;
          end else if (pick < push_cut + (100 - push_cut) * 2 / 3) begin
            req = $urandom_range(0, 1) ? REQ_POP_HI : REQ_POP_LO;
          end else begin
            req = $urandom_range(0, 1) ? REQ_PEEK_HI : REQ_PEEK_LO;
          end
        end
        if ($urandom_range(0, 9) == 0) begin
          case ($urandom_range(0, 3))
            0:       word = 32'h0000_0000;
            1:       word = 32'hFFFF_FFFF;
            2:       word = 32'h7FFF_FFFF;
            default: word = 32'h8000_0000;
          endcase
        end else begin
          word = $urandom;
        end
        send_request(req, word);
      end
    end

    s_axis_tvalid <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Covered %0d requests and %0d responses: %0d overflows, %0d empty reads.",
             board.requests, board.responses, board.overflows, board.empties);
    $display("Backpressure on both sides, long output hold-offs and full drains per phase.");
    if (board.mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/dssm_pkg.sv
rtl/core/dssm_ram.sv
rtl/core/dssm_datapath.sv
rtl/core/dssm_ctrl.sv
rtl/core/dual_stack_shared_memory_unit.sv
tb/sv/testbench.sv
